>>> rtl/core/pdds_pkg.sv
// Shared constants and types for the PID differential drive step unit.
`default_nettype none

package pdds_pkg;

    localparam int INTEGRAL_WIDTH = 32;
    localparam int ERR_W          = 24;
    localparam int GAIN_W         = 16;
    localparam int DRV_W          = 24;
    localparam int CFG_IDX_W      = 2;

    localparam int DERIV_W  = ERR_W + 1;
    localparam int PE_W     = ERR_W + GAIN_W;
    localparam int PI_W     = INTEGRAL_WIDTH + GAIN_W;
    localparam int PD_W     = DERIV_W + GAIN_W;
    localparam int LAT_W    = PI_W + 2;
    localparam int LATC_W   = 43;
    localparam int MIX_W    = LATC_W + 1;
    localparam int SCL_W    = MIX_W + 5;
    localparam int RND_SH   = 12;
    localparam int Q_W      = SCL_W - RND_SH;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LAT_P = 2'd0,
        REG_LAT_I = 2'd1,
        REG_LAT_D = 2'd2,
        REG_ROT_P = 2'd3
    } cfg_reg_t;

    localparam logic signed [GAIN_W-1:0] LAT_P_RESET = 16'sd3072;
    localparam logic signed [GAIN_W-1:0] LAT_I_RESET = 16'sd16;
    localparam logic signed [GAIN_W-1:0] LAT_D_RESET = 16'sd0;
    localparam logic signed [GAIN_W-1:0] ROT_P_RESET = 16'sd3072;

    localparam logic signed [63:0] LAT_LIMIT = 64'sh0000_0200_0000_0000;
    localparam logic signed [63:0] DRV_MAX   = 64'sd8388607;
    localparam logic signed [63:0] DRV_MIN   = -64'sd8388608;
    localparam logic signed [SCL_W-1:0] RND_BIAS = SCL_W'(64'sd2048);

endpackage

`default_nettype wire

>>> rtl/core/pid_differential_drive_step_unit.sv
// Top level: fixed-point PID drive step for a differential drive.
// Throughput: one item per cycle unless the output stalls; four register stages
// (state update, multiply, lateral sum and clamp, mix/scale/round/saturate) advance
// together on one enable.
// Reset: synchronous active-low aresetn clears pipeline valids, integral and
// previous error, and loads the gain reset values.
`default_nettype none

module pid_differential_drive_step_unit
    import pdds_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [ERR_W-1:0]     s_lateral_error,
    input  wire logic signed [ERR_W-1:0]     s_rotation_error,
    input  wire logic                        s_clear_state,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [DRV_W-1:0]          m_left_drive,
    output logic signed [DRV_W-1:0]          m_right_drive,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [GAIN_W-1:0]           cfg_data
);

    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg, rp_reg;

    logic signed [INTEGRAL_WIDTH-1:0] error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0]          last_error_reg, last_error_next;

    logic                             v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic signed [ERR_W-1:0]          e1_reg, r1_reg;
    logic signed [INTEGRAL_WIDTH-1:0] sum1_reg;
    logic signed [DERIV_W-1:0]        d1_reg;
    logic signed [PE_W-1:0]           pe2_reg, pr2_reg, pr3_reg;
    logic signed [PI_W-1:0]           pi2_reg;
    logic signed [PD_W-1:0]           pd2_reg;
    logic signed [LATC_W-1:0]         lat3_reg;
    logic signed [DRV_W-1:0]          left_reg, right_reg;

    logic                             advance;
    logic                             accept;
    logic signed [INTEGRAL_WIDTH:0]   sum_wide;
    logic signed [INTEGRAL_WIDTH-1:0] sum_sat;
    logic signed [DERIV_W-1:0]        deriv;
    logic signed [LAT_W-1:0]          lat_full;
    logic signed [LAT_W-1:0]          lat_clamped;
    logic signed [DRV_W-1:0]          left_next, right_next;

    function automatic logic signed [DRV_W-1:0] drive_out(
        input logic signed [MIX_W-1:0] x
    );
        logic signed [SCL_W-1:0] scaled;
        logic signed [Q_W-1:0]   q;
        logic signed [DRV_W-1:0] res;
        scaled = (SCL_W'(x) <<< 3) + (SCL_W'(x) <<< 2) + RND_BIAS;
        q      = Q_W'(scaled >>> RND_SH);
        if (64'(q) > DRV_MAX) begin
            res = DRV_W'(DRV_MAX);
        end else if (64'(q) < DRV_MIN) begin
            res = DRV_W'(DRV_MIN);
        end else begin
            res = DRV_W'(q);
        end
        return res;
    endfunction

    assign advance   = !m_valid_reg || m_ready;
    assign s_ready   = advance;
    assign accept    = s_valid && advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        sum_wide = (INTEGRAL_WIDTH + 1)'(error_sum_reg)
                 + (INTEGRAL_WIDTH + 1)'(s_lateral_error);
        if (sum_wide[INTEGRAL_WIDTH] != sum_wide[INTEGRAL_WIDTH-1]) begin
            sum_sat = sum_wide[INTEGRAL_WIDTH]
                    ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}}
                    : {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[INTEGRAL_WIDTH-1:0];
        end
        if (last_error_reg == '0) begin
            deriv = '0;
        end else begin
            deriv = DERIV_W'(s_lateral_error) - DERIV_W'(last_error_reg);
        end
        if (s_clear_state) begin
            error_sum_next  = '0;
            last_error_next = '0;
        end else begin
            error_sum_next  = sum_sat;
            last_error_next = s_lateral_error;
        end
    end

    always_comb begin
        lat_full = LAT_W'(pe2_reg) + LAT_W'(pi2_reg) - LAT_W'(pd2_reg);
        if (64'(lat_full) > LAT_LIMIT) begin
            lat_clamped = LAT_W'(LAT_LIMIT);
        end else if (64'(lat_full) < -LAT_LIMIT) begin
            lat_clamped = LAT_W'(-LAT_LIMIT);
        end else begin
            lat_clamped = lat_full;
        end
        left_next  = drive_out(MIX_W'(lat3_reg) - MIX_W'(pr3_reg));
        right_next = drive_out(MIX_W'(lat3_reg) + MIX_W'(pr3_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg <= LAT_P_RESET;
            ki_reg <= LAT_I_RESET;
            kd_reg <= LAT_D_RESET;
            rp_reg <= ROT_P_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LAT_P: kp_reg <= cfg_data;
                REG_LAT_I: ki_reg <= cfg_data;
                REG_LAT_D: kd_reg <= cfg_data;
                REG_ROT_P: rp_reg <= cfg_data;
                default:   kp_reg <= kp_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else if (advance) begin
            if (accept) begin
                error_sum_reg  <= error_sum_next;
                last_error_reg <= last_error_next;
            end
            v1_reg      <= accept;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (s_clear_state) begin
                e1_reg   <= '0;
                r1_reg   <= '0;
                sum1_reg <= '0;
                d1_reg   <= '0;
            end else begin
                e1_reg   <= s_lateral_error;
                r1_reg   <= s_rotation_error;
                sum1_reg <= sum_sat;
                d1_reg   <= deriv;
            end
            pe2_reg   <= PE_W'(e1_reg) * PE_W'(kp_reg);
            pi2_reg   <= PI_W'(sum1_reg) * PI_W'(ki_reg);
            pd2_reg   <= PD_W'(d1_reg) * PD_W'(kd_reg);
            pr2_reg   <= PE_W'(r1_reg) * PE_W'(rp_reg);
            lat3_reg  <= LATC_W'(lat_clamped);
            pr3_reg   <= pr2_reg;
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_left_drive  = left_reg;
    assign m_right_drive = right_reg;

endmodule

`default_nettype wire

>>> rtl/core/pdds_checker.sv
// Port-level checker for the PID differential drive step unit, with its bind.
`default_nettype none

module pdds_checker
    import pdds_pkg::*;
(
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_ready,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic signed [DRV_W-1:0] m_left_drive,
    input wire logic signed [DRV_W-1:0] m_right_drive
);

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while result stalled");

    a_empty_takes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input refused with empty output");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_left_drive)
                                   && $stable(m_right_drive)))
        else $error("stalled result changed");

endmodule

bind pid_differential_drive_step_unit pdds_checker u_pdds_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_left_drive  (m_left_drive),
    .m_right_drive (m_right_drive)
);

`default_nettype wire
